### design/rwde_pkg.sv
// Shared constants and types for the RIFF/WAVE data chunk extractor.
package rwde_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned WordW = 32;
    localparam int unsigned StatusW = 3;

    localparam logic [WordW-1:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [WordW-1:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [WordW-1:0] TAG_DATA = 32'h6461_7461;

    localparam logic [StatusW-1:0] ST_PARSING  = 3'd0;
    localparam logic [StatusW-1:0] ST_DONE_OK  = 3'd1;
    localparam logic [StatusW-1:0] ST_NOT_RIFF = 3'd2;
    localparam logic [StatusW-1:0] ST_NOT_WAVE = 3'd3;
    localparam logic [StatusW-1:0] ST_SIZE_ERR = 3'd4;
    localparam logic [StatusW-1:0] ST_NO_DATA  = 3'd5;

    typedef struct packed {
        logic [ByteW-1:0]   payload_byte;
        logic               payload_valid;
        logic [StatusW-1:0] status;
    } rwde_result_t;

endpackage

### design/riff_wave_data_extractor.sv
// Each accepted input beat gives its result beat on m_ in the following cycle.
// Throughput: one byte per cycle unless m_tready holds the result; the chunk walk is
// a single pass of header, counter and tag-compare logic between the input and the result register.
// s_tready stays high while the result register is empty or being taken.
// Reset (aresetn low, synchronous) returns the parser to the RIFF tag, empties
// the result register and clears expected_data_size to zero.
module riff_wave_data_extractor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rwde_pkg::WordW-1:0]          cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [7:0] stream_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,  // [7:0] payload_byte, [10:8] status
    output logic                                m_tuser   // [0] payload_valid
);
    import rwde_pkg::*;

    logic [WordW-1:0] expected_size_reg;
    logic             m_valid_reg;
    rwde_result_t     result;
    rwde_result_t     result_reg;
    logic             beat_accept;

    assign s_tready    = !m_valid_reg || m_tready;
    assign beat_accept = s_tvalid && s_tready;

    rwde_parser u_parser (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .beat_accept        (beat_accept),
        .beat_byte          (s_tdata),
        .expected_data_size (expected_size_reg),
        .result             (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_size_reg <= '0;
        end else if (cfg_wr_en) begin
            expected_size_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (beat_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_accept) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, result_reg.status, result_reg.payload_byte};
    assign m_tuser  = result_reg.payload_valid;

endmodule

### design/rwde_parser.sv
// Byte-wise RIFF/WAVE chunk walker: parse state and the result for each beat.
module rwde_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             beat_accept,
    input  logic [rwde_pkg::ByteW-1:0]       beat_byte,
    input  logic [rwde_pkg::WordW-1:0]       expected_data_size,
    output rwde_pkg::rwde_result_t           result
);
    import rwde_pkg::*;

    typedef enum logic [3:0] {
        PH_RIFF = 4'd0,
        PH_RLEN = 4'd1,
        PH_WAVE = 4'd2,
        PH_CTAG = 4'd3,
        PH_CLEN = 4'd4,
        PH_SKIP = 4'd5,
        PH_PAD  = 4'd6,
        PH_DATA = 4'd7
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [1:0]         field_idx_reg, field_idx_next;
    logic [WordW-1:0]   field_shift_reg, field_shift_next;
    logic [WordW-1:0]   tag_reg, tag_next;
    logic [WordW-1:0]   bytes_left_reg, bytes_left_next;
    logic [WordW:0]     riff_end_reg, riff_end_next;
    logic [WordW:0]     consumed_reg, consumed_next;
    logic               pad_reg, pad_next;

    logic [WordW-1:0]   tag_shifted;
    logic [WordW-1:0]   len_word;
    logic [WordW+1:0]   consumed_sum;
    logic [WordW:0]     consumed_sat;
    logic               field_last;
    logic               more_chunks;
    logic               more_after_empty;

    assign tag_shifted = {tag_reg[WordW-ByteW-1:0], beat_byte};
    assign len_word    = {beat_byte, field_shift_reg[WordW-ByteW-1:0]};
    assign field_last  = (field_idx_reg == 2'd3);

    // Header plus body plus pad byte, saturating at the 33-bit maximum.
    assign consumed_sum = {1'b0, consumed_reg} + {2'b00, len_word}
                        + (WordW+2)'(8 + {31'd0, len_word[0]});
    assign consumed_sat = consumed_sum[WordW+1] ? '1 : consumed_sum[WordW:0];

    assign more_chunks      = (consumed_reg < riff_end_reg);
    assign more_after_empty = (consumed_sat < riff_end_reg);

    always_comb begin
        phase_next       = phase_reg;
        field_idx_next   = field_idx_reg;
        field_shift_next = field_shift_reg;
        tag_next         = tag_reg;
        bytes_left_next  = bytes_left_reg;
        riff_end_next    = riff_end_reg;
        consumed_next    = consumed_reg;
        pad_next         = pad_reg;
        result.payload_byte  = '0;
        result.payload_valid = 1'b0;
        result.status        = ST_PARSING;

        case (phase_reg)
            PH_RIFF, PH_WAVE, PH_CTAG: begin
                tag_next       = tag_shifted;
                field_idx_next = field_idx_reg + 2'd1;
                if (field_last) begin
                    if (phase_reg == PH_RIFF) begin
                        if (tag_shifted != TAG_RIFF) begin
                            phase_next    = PH_RIFF;
                            result.status = ST_NOT_RIFF;
                        end else begin
                            phase_next = PH_RLEN;
                        end
                    end else if (phase_reg == PH_WAVE) begin
                        if (tag_shifted != TAG_WAVE) begin
                            phase_next    = PH_RIFF;
                            result.status = ST_NOT_WAVE;
                        end else begin
                            consumed_next = (WordW+1)'(4);
                            if ((WordW+1)'(4) < riff_end_reg) begin
                                phase_next = PH_CTAG;
                            end else begin
                                phase_next    = PH_RIFF;
                                result.status = ST_NO_DATA;
                            end
                        end
                    end else begin
                        phase_next = PH_CLEN;
                    end
                end
            end
            PH_RLEN, PH_CLEN: begin
                // Every length field starts at byte 0, so earlier bytes are
                // overwritten in place and the word needs no clearing.
                case (field_idx_reg)
                    2'd0:    field_shift_next[7:0]   = beat_byte;
                    2'd1:    field_shift_next[15:8]  = beat_byte;
                    2'd2:    field_shift_next[23:16] = beat_byte;
                    default: field_shift_next[31:24] = beat_byte;
                endcase
                field_idx_next = field_idx_reg + 2'd1;
                if (field_last) begin
                    if (phase_reg == PH_RLEN) begin
                        riff_end_next = {1'b0, len_word};
                        phase_next    = PH_WAVE;
                    end else if (tag_reg == TAG_DATA) begin
                        if (len_word != expected_data_size) begin
                            phase_next    = PH_RIFF;
                            result.status = ST_SIZE_ERR;
                        end else if (len_word == '0) begin
                            phase_next    = PH_RIFF;
                            result.status = ST_DONE_OK;
                        end else begin
                            bytes_left_next = len_word;
                            phase_next      = PH_DATA;
                        end
                    end else begin
                        consumed_next   = consumed_sat;
                        bytes_left_next = len_word;
                        pad_next        = len_word[0];
                        if (len_word == '0) begin
                            if (more_after_empty) begin
                                phase_next = PH_CTAG;
                            end else begin
                                phase_next    = PH_RIFF;
                                result.status = ST_NO_DATA;
                            end
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
            end
            PH_SKIP: begin
                bytes_left_next = bytes_left_reg - 1'b1;
                if (bytes_left_reg == WordW'(1)) begin
                    if (pad_reg) begin
                        phase_next = PH_PAD;
                    end else if (more_chunks) begin
                        phase_next = PH_CTAG;
                    end else begin
                        phase_next    = PH_RIFF;
                        result.status = ST_NO_DATA;
                    end
                end
            end
            PH_PAD: begin
                pad_next = 1'b0;
                if (more_chunks) begin
                    phase_next = PH_CTAG;
                end else begin
                    phase_next    = PH_RIFF;
                    result.status = ST_NO_DATA;
                end
            end
            PH_DATA: begin
                result.payload_byte  = beat_byte;
                result.payload_valid = 1'b1;
                bytes_left_next      = bytes_left_reg - 1'b1;
                if (bytes_left_reg == WordW'(1)) begin
                    phase_next    = PH_RIFF;
                    result.status = ST_DONE_OK;
                end
            end
            default: begin
                phase_next = PH_RIFF;
            end
        endcase

        // Any final status starts a new file on the next byte.
        if (result.status != ST_PARSING ||
            (phase_next == PH_RIFF && phase_reg != PH_RIFF)) begin
            field_idx_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_RIFF;
            field_idx_reg <= 2'd0;
        end else if (beat_accept) begin
            phase_reg     <= phase_next;
            field_idx_reg <= field_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_accept) begin
            field_shift_reg <= field_shift_next;
            tag_reg         <= tag_next;
            bytes_left_reg  <= bytes_left_next;
            riff_end_reg    <= riff_end_next;
            consumed_reg    <= consumed_next;
            pad_reg         <= pad_next;
        end
    end

    a_final_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_accept && result.status != ST_PARSING |=> phase_reg == PH_RIFF)
        else $error("final status did not return the parser to the RIFF tag");

    a_payload_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        result.payload_valid |-> phase_reg == PH_DATA)
        else $error("payload byte flagged outside the data chunk");

    a_index_in_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        field_idx_reg != 2'd0 |-> (phase_reg == PH_RIFF || phase_reg == PH_RLEN ||
            phase_reg == PH_WAVE || phase_reg == PH_CTAG || phase_reg == PH_CLEN))
        else $error("field byte index left nonzero outside a header field");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !beat_accept |=> $stable(phase_reg) && $stable(field_idx_reg))
        else $error("parse state moved without an accepted beat");

endmodule

### tb/tb.sv
// Self-checking testbench for the RIFF/WAVE data chunk extractor.
`timescale 1ns / 100ps

module tb;
    import rwde_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BYTES   = 190;
    localparam int MAX_PAYLOAD   = 300;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_FACT = 32'h6661_6374;
    localparam logic [31:0] TAG_LIST = 32'h4C49_5354;

    typedef enum logic [3:0] {
        PH_RIFF_TAG, PH_RIFF_LEN, PH_WAVE_TAG, PH_CHUNK_TAG,
        PH_CHUNK_LEN, PH_SKIP, PH_PAD, PH_PAYLOAD
    } parse_phase_e;

    typedef enum int {FK_GOOD, FK_SIZE_ERR, FK_SHORT, FK_BAD_WAVE, FK_BAD_RIFF, FK_NOISE} file_kind_e;

    // Tracks the parser byte by byte and holds the results still to come.
    class wav_result_board;
        logic [31:0]  size_cfg;
        parse_phase_e phase;
        logic [1:0]   idx;
        logic [31:0]  len_acc;
        logic [31:0]  tag_sr;
        logic [31:0]  remaining;
        logic [32:0]  riff_end;
        logic [32:0]  consumed;
        bit           pad;
        rwde_result_t expected_beats[$];
        int           n_fail;
        int           n_payload;
        int           status_seen[8];

        function new();
            size_cfg = '0;
            n_fail = 0;
            n_payload = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_RIFF_TAG;
            idx = '0;
            len_acc = '0;
            tag_sr = '0;
            remaining = '0;
            riff_end = '0;
            consumed = '0;
            pad = 1'b0;
        endfunction

        function void bump(longint unsigned n);
            longint unsigned s;
            s = longint'(consumed) + n;
            if (s > 64'h1_FFFF_FFFF) consumed = '1;
            else consumed = s[32:0];
        endfunction

        // Head of the chunk walk: another header, or no data chunk in this file.
        function logic [StatusW-1:0] walk_on();
            if (consumed < riff_end) begin
                phase = PH_CHUNK_TAG;
                return ST_PARSING;
            end
            restart();
            return ST_NO_DATA;
        endfunction

        function void note_byte(logic [7:0] b);
            rwde_result_t r;
            logic         last;
            logic [31:0]  len;
            r = '0;
            r.status = ST_PARSING;
            case (phase)
                PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_TAG: begin
                    tag_sr = {tag_sr[23:0], b};
                    last = (idx == 2'd3);
                    idx = idx + 2'd1;
                    if (last) begin
                        if (phase == PH_RIFF_TAG) begin
                            if (tag_sr != TAG_RIFF) begin
                                restart();
                                r.status = ST_NOT_RIFF;
                            end else begin
                                phase = PH_RIFF_LEN;
                            end
                        end else if (phase == PH_WAVE_TAG) begin
                            if (tag_sr != TAG_WAVE) begin
                                restart();
                                r.status = ST_NOT_WAVE;
                            end else begin
                                consumed = 33'd4;
                                r.status = walk_on();
                            end
                        end else begin
                            phase = PH_CHUNK_LEN;
                        end
                    end
                end
                PH_RIFF_LEN, PH_CHUNK_LEN: begin
                    len_acc[8*idx +: 8] = b;
                    last = (idx == 2'd3);
                    idx = idx + 2'd1;
                    if (last) begin
                        len = len_acc;
                        len_acc = '0;
                        if (phase == PH_RIFF_LEN) begin
                            riff_end = {1'b0, len};
                            phase = PH_WAVE_TAG;
                        end else if (tag_sr == TAG_DATA) begin
                            bump(8);
                            if (len != size_cfg) begin
                                restart();
                                r.status = ST_SIZE_ERR;
                            end else if (len == 0) begin
                                restart();
                                r.status = ST_DONE_OK;
                            end else begin
                                remaining = len;
                                phase = PH_PAYLOAD;
                            end
                        end else begin
                            bump(8);
                            bump(longint'(len) + len[0]);
                            remaining = len;
                            pad = len[0];
                            if (len == 0) r.status = walk_on();
                            else phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    remaining = remaining - 1;
                    if (remaining == 0) begin
                        if (pad) phase = PH_PAD;
                        else r.status = walk_on();
                    end
                end
                PH_PAD: begin
                    pad = 1'b0;
                    r.status = walk_on();
                end
                PH_PAYLOAD: begin
                    r.payload_byte = b;
                    r.payload_valid = 1'b1;
                    n_payload++;
                    remaining = remaining - 1;
                    if (remaining == 0) begin
                        restart();
                        r.status = ST_DONE_OK;
                    end
                end
                default: restart();
            endcase
            status_seen[r.status]++;
            expected_beats.push_back(r);
        endfunction

        function void check_beat(logic [15:0] data, logic user);
            rwde_result_t want;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: tdata %h tuser %b", data, user);
                n_fail++;
                return;
            end
            want = expected_beats.pop_front();
            if (data[7:0] !== want.payload_byte) begin
                $error("payload_byte: expected %0h, got %0h", want.payload_byte, data[7:0]);
                n_fail++;
            end
            if (user !== want.payload_valid) begin
                $error("payload_valid: expected %0b, got %0b", want.payload_valid, user);
                n_fail++;
            end
            if (data[10:8] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, data[10:8]);
                n_fail++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    wav_result_board sb;
    logic [7:0] file_bytes[$];
    bit tx_calm;
    bit rx_calm;
    bit stall_request;
    int bytes_sent;
    int settings_used;

    riff_wave_data_extractor i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Random gaps, with occasional stretches of back-to-back beats.
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 47) == 0) calm = ~calm;
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic void push_byte(logic [7:0] b);
        file_bytes.push_back(b);
    endfunction

    // Tags go out first character first; lengths go out little-endian.
    function automatic void push_tag(logic [31:0] t);
        for (int k = 3; k >= 0; k--) file_bytes.push_back(t[8*k +: 8]);
    endfunction

    function automatic void push_le(logic [31:0] v);
        for (int k = 0; k < 4; k++) file_bytes.push_back(v[8*k +: 8]);
    endfunction

    function automatic logic [31:0] pick_skip_tag();
        logic [31:0] t;
        case ($urandom_range(0, 4))
            0: t = TAG_FMT;
            1: t = TAG_FACT;
            2: t = TAG_LIST;
            3: t = TAG_DATA ^ (32'h1 << $urandom_range(0, 31));
            default: begin
                do t = $urandom; while (t == TAG_DATA);
            end
        endcase
        return t;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap(tx_calm);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_file();
        while (file_bytes.size() != 0) send_byte(file_bytes.pop_front());
    endtask

    // The register is only written once every result has come back.
    task automatic write_size(input logic [31:0] v);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.size_cfg = v;
        settings_used++;
    endtask

    // Builds one file so that the parser is back at the RIFF tag once it has gone through.
    task automatic build_wav(input file_kind_e kind);
        int unsigned     n_skip;
        int              i;
        logic [31:0]     skip_tag[4];
        logic [31:0]     skip_len[4];
        longint unsigned walked;
        longint unsigned exact;
        logic [31:0]     riff_len;
        logic [31:0]     data_len;
        logic [31:0]     g;
        if (kind == FK_NOISE) begin
            repeat ($urandom_range(1, 4)) begin
                do g = $urandom; while (g == TAG_RIFF);
                push_tag(g);
            end
            return;
        end
        if (kind == FK_BAD_RIFF) begin
            push_tag(TAG_RIFF ^ (32'h1 << $urandom_range(0, 31)));
            return;
        end
        n_skip = $urandom_range(0, 3);
        walked = 4;
        for (i = 0; i < n_skip; i++) begin
            skip_tag[i] = pick_skip_tag();
            skip_len[i] = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 14));
            walked += 8 + skip_len[i] + skip_len[i][0];
        end
        if (kind == FK_SIZE_ERR || sb.size_cfg > MAX_PAYLOAD) begin
            do begin
                if ($urandom_range(0, 1) != 0)
                    data_len = sb.size_cfg ^ (32'h1 << $urandom_range(0, 31));
                else
                    data_len = $urandom_range(0, 40);
            end while (data_len == sb.size_cfg);
        end else begin
            data_len = sb.size_cfg;
        end
        exact = walked + 8 + ((data_len == sb.size_cfg) ? data_len : 0);
        if (kind == FK_SHORT) begin
            riff_len = $urandom_range(0, int'(walked));
        end else begin
            case ($urandom_range(0, 2))
                0: riff_len = exact[31:0];
                1: riff_len = walked[31:0] + 1 + $urandom_range(0, 7);
                default: riff_len = $urandom | 32'h0100_0000;
            endcase
        end
        push_tag(TAG_RIFF);
        push_le(riff_len);
        if (kind == FK_BAD_WAVE) begin
            push_tag(TAG_WAVE ^ (32'h1 << $urandom_range(0, 31)));
            return;
        end
        push_tag(TAG_WAVE);
        walked = 4;
        for (i = 0; i < n_skip; i++) begin
            if (walked >= riff_len) return;
            push_tag(skip_tag[i]);
            push_le(skip_len[i]);
            repeat (skip_len[i] + skip_len[i][0]) push_byte($urandom_range(0, 255));
            walked += 8 + skip_len[i] + skip_len[i][0];
        end
        if (walked >= riff_len) return;
        push_tag(TAG_DATA);
        push_le(data_len);
        if (data_len == sb.size_cfg) repeat (data_len) push_byte($urandom_range(0, 255));
    endtask

    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (stall_request) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                stall_request = 1'b0;
            end
            gap = draw_gap(rx_calm);
            repeat (gap) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_beat(m_tdata, m_tuser);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] sizes[8];
        int          sent_in_phase;
        int          pick;
        file_kind_e  kind;
        sb = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        stall_request = 1'b0;
        bytes_sent = 0;
        settings_used = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed files with an empty data chunk expected.
        write_size(32'd0);
        push_tag(TAG_RIFF ^ 32'h0000_0100);
        push_tag(TAG_RIFF); push_le(32'd4); push_tag(TAG_WAVE);
        push_tag(TAG_RIFF); push_le(32'hFFFF_FFFF); push_tag(TAG_WAVE ^ 32'h8000_0000);
        push_tag(TAG_RIFF); push_le(32'd22); push_tag(TAG_WAVE);
        push_tag(TAG_FMT); push_le(32'd1); push_byte(8'hFF); push_byte(8'h00);
        push_tag(TAG_DATA); push_le(32'd0);
        send_file();

        // Directed files with a three-byte data chunk expected.
        write_size(32'd3);
        push_tag(TAG_RIFF); push_le(32'd5); push_tag(TAG_WAVE);
        push_tag(TAG_LIST); push_le(32'd0);
        push_tag(TAG_RIFF); push_le(32'd40); push_tag(TAG_WAVE);
        push_tag(TAG_FACT); push_le(32'd0);
        push_tag(TAG_DATA); push_le(32'd3); push_byte(8'h00); push_byte(8'hFF); push_byte(8'h5A);
        push_tag(TAG_RIFF); push_le(32'd40); push_tag(TAG_WAVE);
        push_tag(TAG_DATA); push_le(32'd2);
        push_tag(TAG_RIFF); push_le(32'd12); push_tag(TAG_WAVE);
        push_tag(TAG_FMT); push_le(32'd2); push_byte(8'h12); push_byte(8'h34);
        send_file();

        sizes[0] = 32'd0;
        sizes[1] = 32'hFFFF_FFFF;
        sizes[2] = 32'd1;
        sizes[3] = 32'd256;
        sizes[4] = $urandom_range(2, 12);
        sizes[5] = $urandom_range(13, 64);
        sizes[6] = $urandom | 32'h8000_0000;
        sizes[7] = $urandom_range(1, 24);
        foreach (sizes[p]) begin
            write_size(sizes[p]);
            // Hold the result side off during the long-payload phase so the input backs up.
            if (p == 3) stall_request = 1'b1;
            sent_in_phase = 0;
            while (sent_in_phase < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) kind = FK_GOOD;
                else if (pick < 70) kind = FK_SIZE_ERR;
                else if (pick < 78) kind = FK_SHORT;
                else if (pick < 84) kind = FK_BAD_WAVE;
                else if (pick < 90) kind = FK_BAD_RIFF;
                else kind = FK_NOISE;
                build_wav(kind);
                sent_in_phase += file_bytes.size();
                send_file();
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (sb.expected_beats.size() != 0) begin
            $error("%0d results never arrived", sb.expected_beats.size());
            sb.n_fail++;
        end
        $display("Sent %0d bytes over %0d sizes; %0d files parsed clean, %0d payload bytes.",
                 bytes_sent, settings_used, sb.status_seen[ST_DONE_OK], sb.n_payload);
        $display("Errors: not RIFF %0d, not WAVE %0d, size mismatch %0d, no data chunk %0d.",
                 sb.status_seen[ST_NOT_RIFF], sb.status_seen[ST_NOT_WAVE],
                 sb.status_seen[ST_SIZE_ERR], sb.status_seen[ST_NO_DATA]);
        if (sb.n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
